// ===== rtl/wfdg_pkg.sv =====
// shared constants, register codes and a helper function for the ws2812 frame duty generator
package wfdg_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;
    localparam int PosW     = 14;
    localparam int BitsPerLed = 24;

    // register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] CFG_LED_COUNT     = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_RESET_LEN     = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_DUTY_ONE      = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_DUTY_ZERO     = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_DUTY_RESET    = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_REFRESH_MS    = 3'd5;

    // reset values of the registers
    localparam logic [8:0]  LED_COUNT_RST     = 9'd2;
    localparam logic [9:0]  RESET_LEN_RST     = 10'd240;
    localparam logic [7:0]  DUTY_ONE_RST      = 8'd26;
    localparam logic [7:0]  DUTY_ZERO_RST     = 8'd51;
    localparam logic [7:0]  DUTY_RESET_RST    = 8'd80;
    localparam logic [15:0] REFRESH_MS_RST    = 16'd1000;

    // operation codes of an input item
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // byte order on the wire
    localparam logic [1:0] SEL_GREEN = 2'd0;
    localparam logic [1:0] SEL_RED   = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

    // x mod 3 by summing base-4 digits, then one more fold
    function automatic logic [1:0] mod3(input logic [PosW-1:0] x);
        logic [4:0] s;
        logic [2:0] t;
        s = '0;
        for (int i = 0; i < PosW / 2; i++)
        begin
            s = s + 5'(x[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6)
        begin
            t = t - 3'd6;
        end
        else if (t >= 3'd3)
        begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

endpackage

// ===== rtl/wfdg_if.sv =====
// valid/ready channel interfaces for the input and result items
interface wfdg_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] now_ms;
    logic [23:0] color;

    modport source (output valid, output op, output now_ms, output color, input ready);
    modport sink   (input valid, input op, input now_ms, input color, output ready);
endinterface

interface wfdg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty;
    logic       started;
    logic       active;

    modport source (output valid, output duty, output started, output active, input ready);
    modport sink   (input valid, input duty, input started, input active, output ready);
endinterface

// ===== rtl/ws2812_frame_duty_generator.sv =====
// top level of the ws2812 frame duty generator
// Each item is either an update request (op 0) or a pwm period tick (op 1) and gives exactly one
// result item. An item is registered on entry, evaluated against the frame state in one short
// combinational step and registered again on exit, and one item is taken every cycle as long
// as the result side keeps up; a full result register stalls the input stage. A request starts
// a frame when no frame runs and the colour changed, nothing was sent yet, or refresh_ms elapsed
// since the last start. Ticks then give a reset run of duty_reset values, 24 bits per led
// (green, red, blue, msb first) as duty_one or duty_zero, another reset run, and a final park
// value 0; idle ticks give 0. Registers take effect on the next item.
module ws2812_frame_duty_generator
    import wfdg_pkg::*;
#(
    parameter int MAX_LEDS          = 256,
    parameter int MAX_RESET_PERIODS = 1023
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    wfdg_in_if.sink             in_ch,
    wfdg_out_if.source          out_ch
);

    localparam int LedW = $clog2(MAX_LEDS + 1);
    localparam int RstW = $clog2(MAX_RESET_PERIODS + 1);

    // configuration
    logic [8:0]  led_count_reg;
    logic [9:0]  reset_len_reg;
    logic [7:0]  duty_one_reg;
    logic [7:0]  duty_zero_reg;
    logic [7:0]  duty_reset_reg;
    logic [15:0] refresh_ms_reg;

    // frame state
    logic [23:0]     sent_color_reg, sent_color_next;
    logic            never_sent_reg, never_sent_next;
    logic [31:0]     sent_time_reg, sent_time_next;
    logic            busy_reg, busy_next;
    logic [PosW-1:0] pos_reg, pos_next;

    // input stage
    logic        s1_valid_reg;
    logic        s1_op_reg;
    logic [31:0] s1_now_reg;
    logic [23:0] s1_color_reg;

    // result stage
    logic       out_valid_reg;
    logic [7:0] out_duty_reg, duty_next;
    logic       out_started_reg, started_next;
    logic       out_active_reg;

    logic advance;
    logic in_take;

    logic [LedW-1:0] leds_eff;
    logic [RstW-1:0] rst_eff;
    logic [PosW-1:0] rst_len;
    logic [PosW-1:0] data_len;
    logic [PosW-1:0] data_end;
    logic [PosW-1:0] frame_last;
    logic [PosW-1:0] rel;
    logic [1:0]      byte_sel;
    logic [2:0]      bit_idx;
    logic [7:0]      byte_val;
    logic [31:0]     elapsed;
    logic            due;

    assign advance      = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !s1_valid_reg || advance;
    assign in_take      = in_ch.valid && in_ch.ready;

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.duty    = out_duty_reg;
    assign out_ch.started = out_started_reg;
    assign out_ch.active  = out_active_reg;

    // clamped frame geometry
    always_comb
    begin
        if (led_count_reg == 9'd0)
        begin
            leds_eff = LedW'(1);
        end
        else if (led_count_reg > 9'(MAX_LEDS))
        begin
            leds_eff = LedW'(MAX_LEDS);
        end
        else
        begin
            leds_eff = led_count_reg[LedW-1:0];
        end

        if (reset_len_reg > 10'(MAX_RESET_PERIODS))
        begin
            rst_eff = RstW'(MAX_RESET_PERIODS);
        end
        else
        begin
            rst_eff = reset_len_reg[RstW-1:0];
        end
    end

    assign rst_len    = PosW'(rst_eff);
    assign data_len   = PosW'(leds_eff) * PosW'(BitsPerLed);
    assign data_end   = rst_len + data_len;
    assign frame_last = data_end + rst_len;
    assign rel        = pos_reg - rst_len;
    assign byte_sel   = mod3(rel >> 3);
    assign bit_idx    = ~rel[2:0];

    always_comb
    begin
        case (byte_sel)
            SEL_GREEN: byte_val = sent_color_reg[15:8];
            SEL_RED:   byte_val = sent_color_reg[23:16];
            default:   byte_val = sent_color_reg[7:0];
        endcase
    end

    assign elapsed = s1_now_reg - sent_time_reg;
    assign due     = never_sent_reg || (s1_color_reg != sent_color_reg)
                     || (elapsed >= {16'd0, refresh_ms_reg});

    always_comb
    begin
        sent_color_next = sent_color_reg;
        never_sent_next = never_sent_reg;
        sent_time_next  = sent_time_reg;
        busy_next       = busy_reg;
        pos_next        = pos_reg;
        duty_next       = 8'd0;
        started_next    = 1'b0;

        if (s1_op_reg == OP_TICK)
        begin
            if (busy_reg)
            begin
                if (pos_reg >= frame_last)
                begin
                    // park period closes the frame
                    busy_next = 1'b0;
                    pos_next  = '0;
                end
                else
                begin
                    if (pos_reg < rst_len || pos_reg >= data_end)
                    begin
                        duty_next = duty_reset_reg;
                    end
                    else if (byte_val[bit_idx])
                    begin
                        duty_next = duty_one_reg;
                    end
                    else
                    begin
                        duty_next = duty_zero_reg;
                    end
                    pos_next = pos_reg + PosW'(1);
                end
            end
        end
        else if (due && !busy_reg)
        begin
            sent_color_next = s1_color_reg;
            sent_time_next  = s1_now_reg;
            never_sent_next = 1'b0;
            busy_next       = 1'b1;
            pos_next        = '0;
            started_next    = 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg     <= LED_COUNT_RST;
            reset_len_reg     <= RESET_LEN_RST;
            duty_one_reg      <= DUTY_ONE_RST;
            duty_zero_reg     <= DUTY_ZERO_RST;
            duty_reset_reg    <= DUTY_RESET_RST;
            refresh_ms_reg    <= REFRESH_MS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LED_COUNT:     led_count_reg     <= cfg_data[8:0];
                CFG_RESET_LEN:     reset_len_reg     <= cfg_data[9:0];
                CFG_DUTY_ONE:      duty_one_reg      <= cfg_data[7:0];
                CFG_DUTY_ZERO:     duty_zero_reg     <= cfg_data[7:0];
                CFG_DUTY_RESET:    duty_reset_reg    <= cfg_data[7:0];
                CFG_REFRESH_MS:    refresh_ms_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // frame state and handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_color_reg <= '0;
            never_sent_reg <= 1'b1;
            sent_time_reg  <= '0;
            busy_reg       <= 1'b0;
            pos_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                sent_color_reg <= sent_color_next;
                never_sent_reg <= never_sent_next;
                sent_time_reg  <= sent_time_next;
                busy_reg       <= busy_next;
                pos_reg        <= pos_next;
            end

            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg    <= in_ch.op;
            s1_now_reg   <= in_ch.now_ms;
            s1_color_reg <= in_ch.color;
        end
        if (advance)
        begin
            out_duty_reg    <= duty_next;
            out_started_reg <= started_next;
            out_active_reg  <= busy_next;
        end
    end

endmodule

// ===== tb/wfdg_checker.sv =====
// result predictor and checker for the ws2812 frame duty generator
`timescale 1ns / 100ps

module wfdg_checker
    import wfdg_pkg::*;
#(
    parameter int MAX_LEDS          = 256,
    parameter int MAX_RESET_PERIODS = 1023
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    wfdg_in_if                  in_mon,
    wfdg_out_if                 out_mon,
    output int                  mismatches,
    output int                  results_waiting,
    output logic                frame_running,
    output int                  results_seen,
    output int                  frames_begun
);

    typedef struct packed {
        logic [7:0] duty;
        logic       started;
        logic       active;
    } duty_result_t;

    duty_result_t expected_duty_q[$];
    duty_result_t want;
    duty_result_t got;

    // register copies
    logic [8:0]  led_count;
    logic [9:0]  reset_len;
    logic [7:0]  duty_one;
    logic [7:0]  duty_zero;
    logic [7:0]  duty_reset;
    logic [15:0] refresh_ms;

    // frame state
    logic [23:0]     sent_color;
    logic            never_sent;
    logic [31:0]     sent_time;
    logic            busy;
    logic [PosW-1:0] position;

    int err_count;
    int result_count;
    int start_count;

    function automatic logic [7:0] next_tick_duty();
        int         leds;
        int         rst_len;
        int         data_len;
        int         p;
        int         k;
        logic [1:0] byte_sel;
        logic [7:0] chan;
        logic [7:0] level;
        leds = (led_count == 0) ? 1 : (led_count > MAX_LEDS) ? MAX_LEDS : int'(led_count);
        rst_len = (reset_len > MAX_RESET_PERIODS) ? MAX_RESET_PERIODS : int'(reset_len);
        data_len = leds * BitsPerLed;
        p = int'(position);
        // also covers a frame cut short by a register change
        if (p >= 2 * rst_len + data_len)
        begin
            busy = 1'b0;
            position = '0;
            return 8'd0;
        end
        if (p < rst_len || p >= rst_len + data_len)
        begin
            level = duty_reset;
        end
        else
        begin
            k = (p - rst_len) % BitsPerLed;
            byte_sel = 2'(k / 8);
            case (byte_sel)
                SEL_GREEN: chan = sent_color[15:8];
                SEL_RED:   chan = sent_color[23:16];
                default:   chan = sent_color[7:0];
            endcase
            level = chan[7 - k % 8] ? duty_one : duty_zero;
        end
        position = position + 1'b1;
        return level;
    endfunction

    function automatic duty_result_t predict_result(input logic op, input logic [31:0] now,
                                                    input logic [23:0] color);
        duty_result_t res;
        logic [31:0]  elapsed;
        res = '0;
        elapsed = now - sent_time;
        if (op == OP_TICK)
        begin
            if (busy)
            begin
                res.duty = next_tick_duty();
            end
        end
        else if (!busy && (never_sent || color != sent_color || elapsed >= 32'(refresh_ms)))
        begin
            sent_color = color;
            sent_time = now;
            never_sent = 1'b0;
            busy = 1'b1;
            position = '0;
            res.started = 1'b1;
            start_count++;
        end
        res.active = busy;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count = LED_COUNT_RST;
            reset_len = RESET_LEN_RST;
            duty_one = DUTY_ONE_RST;
            duty_zero = DUTY_ZERO_RST;
            duty_reset = DUTY_RESET_RST;
            refresh_ms = REFRESH_MS_RST;
            sent_color = '0;
            never_sent = 1'b1;
            sent_time = '0;
            busy = 1'b0;
            position = '0;
            expected_duty_q.delete();
            err_count = 0;
            result_count = 0;
            start_count = 0;
            mismatches <= 0;
            results_waiting <= 0;
            frame_running <= 1'b0;
            results_seen <= 0;
            frames_begun <= 0;
        end
        else
        begin
            // compare before pushing so a same-edge result never matches its own item
            if (out_mon.valid && out_mon.ready)
            begin
                result_count++;
                got = {out_mon.duty, out_mon.started, out_mon.active};
                if (expected_duty_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                    begin
                        $display("unexpected result item: duty %0d started %0b active %0b",
                                 got.duty, got.started, got.active);
                    end
                end
                else
                begin
                    want = expected_duty_q.pop_front();
                    if (want !== got)
                    begin
                        err_count++;
                        if (err_count <= 10)
                        begin
                            $display("result %0d: expected duty %0d started %0b active %0b",
                                     result_count, want.duty, want.started, want.active);
                            $display("  got duty %0d started %0b active %0b",
                                     got.duty, got.started, got.active);
                        end
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LED_COUNT:     led_count = cfg_data[8:0];
                    CFG_RESET_LEN:     reset_len = cfg_data[9:0];
                    CFG_DUTY_ONE:      duty_one = cfg_data[7:0];
                    CFG_DUTY_ZERO:     duty_zero = cfg_data[7:0];
                    CFG_DUTY_RESET:    duty_reset = cfg_data[7:0];
                    CFG_REFRESH_MS:    refresh_ms = cfg_data[15:0];
                    default: ;
                endcase
            end

            if (in_mon.valid && in_mon.ready)
            begin
                expected_duty_q.push_back(predict_result(in_mon.op, in_mon.now_ms, in_mon.color));
            end

            mismatches <= err_count;
            results_waiting <= expected_duty_q.size();
            frame_running <= busy;
            results_seen <= result_count;
            frames_begun <= start_count;
        end
    end

endmodule

// ===== tb/ws2812_frame_duty_generator_tb.sv =====
// testbench top for the ws2812 frame duty generator: stimulus, stalls, watchdog and verdict
`timescale 1ns / 100ps

module ws2812_frame_duty_generator_tb;
    import wfdg_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_PHASES  = 10;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data  = '0;
    logic                sink_ready = 1'b0;

    wfdg_in_if  in_ch();
    wfdg_out_if out_ch();

    int   mismatches;
    int   results_waiting;
    logic frame_running;
    int   results_seen;
    int   frames_begun;

    int          burst_left     = 0;
    int          idle_cycles    = 0;
    int          items_sent     = 0;
    int          settings_used  = 0;
    logic [31:0] clock_ms       = '0;
    logic [23:0] last_color     = '0;
    logic [15:0] cur_refresh    = '0;
    logic [15:0] ready_pattern  = '1;
    int          pattern_age    = 0;

    assign out_ch.ready = sink_ready;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    ws2812_frame_duty_generator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    wfdg_checker duty_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_mon          (in_ch),
        .out_mon         (out_ch),
        .mismatches      (mismatches),
        .results_waiting (results_waiting),
        .frame_running   (frame_running),
        .results_seen    (results_seen),
        .frames_begun    (frames_begun)
    );

    // result side stalls on a rotating pattern, reloaded now and then
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
        end
        else
        begin
            sink_ready <= ready_pattern[0];
            if (pattern_age == 47)
            begin
                pattern_age <= 0;
                if ($urandom_range(0, 2) == 0)
                begin
                    ready_pattern <= '1;
                end
                else
                begin
                    ready_pattern <= 16'($urandom) | 16'h0001;
                end
            end
            else
            begin
                pattern_age <= pattern_age + 1;
                ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("no item moved for %0d cycles", idle_cycles);
                $display("== FAIL ==");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [8:0] leds, input logic [9:0] rst_len,
                                  input logic [7:0] one, input logic [7:0] zero,
                                  input logic [7:0] rst_duty, input logic [15:0] refresh);
        write_reg(CFG_LED_COUNT, CfgDataW'(leds));
        write_reg(CFG_RESET_LEN, CfgDataW'(rst_len));
        write_reg(CFG_DUTY_ONE, CfgDataW'(one));
        write_reg(CFG_DUTY_ZERO, CfgDataW'(zero));
        write_reg(CFG_DUTY_RESET, CfgDataW'(rst_duty));
        write_reg(CFG_REFRESH_MS, CfgDataW'(refresh));
        cfg_we <= 1'b0;
        cur_refresh = refresh;
        settings_used++;
    endtask

    // hold off the sender until every expected result item is back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (results_waiting != 0);
    endtask

    task automatic send_item(input logic op, input logic [31:0] now, input logic [23:0] color);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 10);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.now_ms <= now;
        in_ch.color <= color;
        do @(posedge clk); while (!in_ch.ready);
        burst_left--;
        items_sent++;
    endtask

    // idle block: mostly requests; running frame: mostly ticks
    task automatic send_random_item(output bit useful);
        logic        op;
        logic [31:0] now;
        logic [23:0] color;
        int          pick;
        pick = $urandom_range(0, 15);
        op = frame_running ? (pick != 0) : (pick < 4);
        useful = (op == OP_TICK) == frame_running;
        if (op == OP_TICK)
        begin
            now = $urandom;
            color = 24'($urandom);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0, 1: color = last_color;
                2:
                begin
                    case ($urandom_range(0, 3))
                        0: color = 24'h000000;
                        1: color = 24'hFFFFFF;
                        2: color = 24'h800001;
                        default: color = 24'h55AA0F;
                    endcase
                end
                default: color = 24'($urandom);
            endcase
            if ($urandom_range(0, 31) == 0)
            begin
                clock_ms = $urandom;
            end
            else
            begin
                clock_ms = clock_ms + 32'($urandom_range(0, 2 * int'(cur_refresh) + 2));
            end
            now = clock_ms;
            last_color = color;
        end
        send_item(op, now, color);
    endtask

    initial
    begin
        int budget;
        int done_count;
        int pause_at;
        bit useful;

        in_ch.valid <= 1'b0;
        in_ch.op <= OP_UPDATE;
        in_ch.now_ms <= '0;
        in_ch.color <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: one led (count 0), no reset run, so a frame is 24 bits and a park
        apply_settings(9'd0, 10'd0, 8'hFF, 8'h01, 8'h5A, 16'hFFFF);
        send_item(OP_TICK, 32'hFFFF_FFFF, 24'hFFFFFF);
        send_item(OP_UPDATE, 32'hFFFF_FFF0, 24'h000000);
        send_item(OP_UPDATE, 32'h0000_0000, 24'hFFFFFF);
        repeat (25) send_item(OP_TICK, 32'h0000_0000, 24'h000000);
        // same colour one ms short of the interval, then exactly at it across the wrap
        send_item(OP_UPDATE, 32'h0000_FFEE, 24'h000000);
        send_item(OP_UPDATE, 32'h0000_FFEF, 24'h000000);
        send_item(OP_TICK, 32'h0000_0000, 24'h000000);
        clock_ms = 32'h0000_FFEF;
        last_color = 24'h000000;

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain_results();
            repeat (SETTLE_CYCLES) @(posedge clk);
            // phases 1 and 3 stop inside a long frame; the next setting cuts it short
            case (ph)
                0:
                begin
                    apply_settings(9'd0, 10'd0, 8'd255, 8'd0, 8'd128, 16'd0);
                    budget = 170;
                end
                1:
                begin
                    apply_settings(9'd511, 10'd1023, 8'd0, 8'd255, 8'd255, 16'd65535);
                    budget = 120;
                end
                2:
                begin
                    apply_settings(9'd2, 10'd3, 8'($urandom), 8'($urandom), 8'($urandom),
                                   16'd300);
                    budget = 170;
                end
                3:
                begin
                    apply_settings(9'd256, 10'd0, 8'($urandom), 8'($urandom), 8'($urandom),
                                   16'd2000);
                    budget = 150;
                end
                default:
                begin
                    apply_settings(9'($urandom_range(1, 4)), 10'($urandom_range(0, 8)),
                                   8'($urandom), 8'($urandom), 8'($urandom),
                                   ($urandom_range(0, 3) == 0) ? 16'd0 :
                                   ($urandom_range(0, 2) == 0) ? 16'($urandom) :
                                   16'($urandom_range(1, 3000)));
                    budget = 130;
                end
            endcase
            done_count = 0;
            pause_at = $urandom_range(budget / 4, 3 * budget / 4);
            while (done_count < budget)
            begin
                send_random_item(useful);
                if (useful)
                begin
                    done_count++;
                end
                if (done_count == pause_at)
                begin
                    drain_results();
                    pause_at = -1;
                end
            end
        end

        drain_results();
        repeat (8) @(posedge clk);

        $display("sent %0d items under %0d register settings, %0d frames started",
                 items_sent, settings_used, frames_begun);
        $display("checked %0d result items, led counts 0 to 511, reset runs 0 to 1023",
                 results_seen);
        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("%0d mismatching result items", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
